// ----- src/poi_pkg.sv -----
// Shared types and constants for the planar odometry integrator.
`timescale 1ns / 1ps
package poi_pkg;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_SET       = 1'b1;

  localparam logic [28:0] HEAD_SCALE  = 29'd341782638;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032875;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic        operation;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] yaw_rate;
    logic [19:0] time_step;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [31:0] pose_heading;
  } item_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- src/poi_front.sv -----
// Input side: accepts words and queues them in a two-entry buffer for the back end.
`timescale 1ns / 1ps
module poi_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  poi_pkg::item_t in_item,
  output logic           q_valid,
  output poi_pkg::item_t q_item,
  input  logic           q_pop
);

  poi_pkg::item_t buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ----- src/poi_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a full-turn binary angle.
`timescale 1ns / 1ps
module poi_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  output logic        done,
  output logic [31:0] cos_q30,
  output logic [31:0] sin_q30
);

  localparam int IW = $clog2(CORDIC_STEPS);

  logic                 busy_r;
  logic                 done_r;
  logic                 flip_r;
  logic [IW-1:0]        i_r;
  logic signed [33:0]   x_r, y_r, z_r;
  logic signed [33:0]   x_nxt, y_nxt, z_nxt;
  logic signed [33:0]   xs, ys, at;
  logic signed [33:0]   xf, yf;
  logic [31:0]          cos_r, sin_r;
  logic                 flip;
  logic [31:0]          a;

  assign done    = done_r;
  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

  function automatic logic [31:0] clamp(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > poi_pkg::ONE_Q30) begin
      r = poi_pkg::ONE_Q30[31:0];
    end else if (v < -poi_pkg::ONE_Q30) begin
      r = 32'(-poi_pkg::ONE_Q30);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    flip  = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    a     = flip ? (angle + 32'h80000000) : angle;
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    at    = $signed({2'b00, poi_pkg::atan_lut(5'(i_r))});
    if (!z_r[33]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
    xf = flip_r ? -x_nxt : x_nxt;
    yf = flip_r ? -y_nxt : y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (i_r == IW'(CORDIC_STEPS - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      i_r    <= '0;
      x_r    <= $signed({2'b00, poi_pkg::CORDIC_GAIN});
      y_r    <= '0;
      z_r    <= $signed({{2{a[31]}}, a});
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 1'b1;
      if (i_r == IW'(CORDIC_STEPS - 1)) begin
        cos_r <= clamp(xf);
        sin_r <= clamp(yf);
      end
    end
  end

endmodule

// ----- src/poi_back.sv -----
// Execution side: set pose or heading step, displacement rotation, saturation, quaternion and the result register.
`timescale 1ns / 1ps
module poi_back #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  poi_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_pos_x,
  output logic [31:0]    out_pos_y,
  output logic [31:0]    out_heading,
  output logic [31:0]    out_quat_w,
  output logic [31:0]    out_quat_z,
  output logic [31:0]    out_lin_vel_x,
  output logic [31:0]    out_lin_vel_y,
  output logic [31:0]    out_ang_vel,
  output logic           out_saturated
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_MUL_P   = 16'h0002,
    S_MUL_DL  = 16'h0004,
    S_MUL_DH  = 16'h0008,
    S_MUL_VX  = 16'h0010,
    S_MUL_VY  = 16'h0020,
    S_ROT_GO  = 16'h0040,
    S_ROT_WT  = 16'h0080,
    S_MUL_XC  = 16'h0100,
    S_MUL_YS  = 16'h0200,
    S_MUL_XS  = 16'h0400,
    S_MUL_YC  = 16'h0800,
    S_ACC     = 16'h1000,
    S_QUAT_GO = 16'h2000,
    S_QUAT_WT = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  state_t st_r, st_nxt;

  logic [31:0]        x_r, y_r, heading_r, vx_r, vy_r, wz_r;
  logic [19:0]        dt_r;
  logic               sat_r;
  logic signed [52:0] p_r;
  logic [28:0]        dlo_r;
  logic signed [34:0] dxq_r, dyq_r;
  logic [31:0]        c_r, s_r, qw_r, qz_r;
  logic signed [39:0] tx_r, ty_r;

  logic [51:0]        mag;
  logic [60:0]        lo_prod;
  logic [48:0]        hi_prod;
  logic [48:0]        d_sum;
  logic [31:0]        step;
  logic signed [52:0] vx_prod, vy_prod;
  logic signed [66:0] m_prod;
  logic signed [34:0] m_a;
  logic [31:0]        m_b;
  logic signed [38:0] m_term;
  logic signed [40:0] sum_x, sum_y;
  logic               ovf_x, ovf_y;
  logic [31:0]        sat_x, sat_y;

  logic               cd_start, cd_done;
  logic [31:0]        cd_angle, cd_cos, cd_sin;

  logic        out_valid_r;
  logic [31:0] o_x_r, o_y_r, o_h_r, o_w_r, o_z_r, o_vx_r, o_vy_r, o_wz_r;
  logic        o_sat_r;

  poi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cd_start),
    .angle   (cd_angle),
    .done    (cd_done),
    .cos_q30 (cd_cos),
    .sin_q30 (cd_sin)
  );

  assign cd_start = (st_r == S_ROT_GO) || (st_r == S_QUAT_GO);
  assign cd_angle = (st_r == S_ROT_GO) ? {heading_r[30:0], 1'b0} : heading_r;
  assign q_pop    = (st_r == S_IDLE) && q_valid;

  always_comb begin
    mag     = p_r[52] ? 52'(-p_r) : 52'(p_r);
    lo_prod = 61'(mag[31:0]) * 61'(poi_pkg::HEAD_SCALE);
    hi_prod = 49'(mag[51:32]) * 49'(poi_pkg::HEAD_SCALE);
    d_sum   = hi_prod + 49'(dlo_r);
    step    = p_r[52] ? (32'd0 - d_sum[31:0]) : d_sum[31:0];
    vx_prod = $signed(vx_r) * $signed({1'b0, dt_r});
    vy_prod = $signed(vy_r) * $signed({1'b0, dt_r});
    unique case (st_r)
      S_MUL_YS: begin m_a = dyq_r; m_b = s_r; end
      S_MUL_XS: begin m_a = dxq_r; m_b = s_r; end
      S_MUL_YC: begin m_a = dyq_r; m_b = c_r; end
      default:  begin m_a = dxq_r; m_b = c_r; end
    endcase
    m_prod = m_a * $signed(m_b);
    m_term = m_prod[66:28];
    sum_x  = $signed({{9{x_r[31]}}, x_r}) + $signed({tx_r[39], tx_r});
    sum_y  = $signed({{9{y_r[31]}}, y_r}) + $signed({ty_r[39], ty_r});
    ovf_x  = (sum_x[40:31] != {10{sum_x[40]}});
    ovf_y  = (sum_y[40:31] != {10{sum_y[40]}});
    sat_x  = ovf_x ? (sum_x[40] ? 32'h80000000 : 32'h7FFFFFFF) : sum_x[31:0];
    sat_y  = ovf_y ? (sum_y[40] ? 32'h80000000 : 32'h7FFFFFFF) : sum_y[31:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          st_nxt = (q_item.operation == poi_pkg::OP_SET) ? S_QUAT_GO : S_MUL_P;
        end
      end
      S_MUL_P:   st_nxt = S_MUL_DL;
      S_MUL_DL:  st_nxt = S_MUL_DH;
      S_MUL_DH:  st_nxt = S_MUL_VX;
      S_MUL_VX:  st_nxt = S_MUL_VY;
      S_MUL_VY:  st_nxt = S_ROT_GO;
      S_ROT_GO:  st_nxt = S_ROT_WT;
      S_ROT_WT:  st_nxt = cd_done ? S_MUL_XC : S_ROT_WT;
      S_MUL_XC:  st_nxt = S_MUL_YS;
      S_MUL_YS:  st_nxt = S_MUL_XS;
      S_MUL_XS:  st_nxt = S_MUL_YC;
      S_MUL_YC:  st_nxt = S_ACC;
      S_ACC:     st_nxt = S_QUAT_GO;
      S_QUAT_GO: st_nxt = S_QUAT_WT;
      S_QUAT_WT: st_nxt = cd_done ? S_DONE : S_QUAT_WT;
      S_DONE:    st_nxt = (!out_valid_r || !out_stall) ? S_IDLE : S_DONE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      heading_r   <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      wz_r        <= '0;
    end else begin
      st_r <= st_nxt;
      // load a new word, hold a stalled one, drop a taken one
      out_valid_r <= ((st_r == S_DONE) && (!out_valid_r || !out_stall)) ||
                     (out_valid_r && out_stall);
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            sat_r <= 1'b0;
            dt_r  <= q_item.time_step;
            if (q_item.operation == poi_pkg::OP_SET) begin
              x_r       <= q_item.pose_x;
              y_r       <= q_item.pose_y;
              heading_r <= q_item.pose_heading;
            end else begin
              vx_r <= q_item.vel_x;
              vy_r <= q_item.vel_y;
              wz_r <= q_item.yaw_rate;
            end
          end
        end
        S_MUL_P:  p_r <= $signed(wz_r) * $signed({1'b0, dt_r});
        S_MUL_DL: dlo_r <= lo_prod[60:32];
        S_MUL_DH: heading_r <= heading_r + step;
        S_MUL_VX: dxq_r <= vx_prod[52:18];
        S_MUL_VY: dyq_r <= vy_prod[52:18];
        S_ROT_WT: begin
          if (cd_done) begin
            c_r <= cd_cos;
            s_r <= cd_sin;
          end
        end
        S_MUL_XC: tx_r <= {m_term[38], m_term};
        S_MUL_YS: tx_r <= tx_r - {m_term[38], m_term};
        S_MUL_XS: ty_r <= {m_term[38], m_term};
        S_MUL_YC: ty_r <= ty_r + {m_term[38], m_term};
        S_ACC: begin
          x_r   <= sat_x;
          y_r   <= sat_y;
          sat_r <= ovf_x || ovf_y;
        end
        S_QUAT_WT: begin
          if (cd_done) begin
            qw_r <= cd_cos;
            qz_r <= cd_sin;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            o_x_r       <= x_r;
            o_y_r       <= y_r;
            o_h_r       <= heading_r;
            o_w_r       <= qw_r;
            o_z_r       <= qz_r;
            o_vx_r      <= vx_r;
            o_vy_r      <= vy_r;
            o_wz_r      <= wz_r;
            o_sat_r     <= sat_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = o_x_r;
  assign out_pos_y     = o_y_r;
  assign out_heading   = o_h_r;
  assign out_quat_w    = o_w_r;
  assign out_quat_z    = o_z_r;
  assign out_lin_vel_x = o_vx_r;
  assign out_lin_vel_y = o_vy_r;
  assign out_ang_vel   = o_wz_r;
  assign out_saturated = o_sat_r;

endmodule

// ----- src/planar_odometry_integrator.sv -----
// Top level of the planar dead-reckoning odometry integrator.
// Usage:
//   Input channel in_*: one word per update, in_operation selects integrate
//   (velocities over in_time_step) or set pose. Accepted when in_valid is
//   high and in_stall low. A two-entry queue takes words while the engine
//   works, so in_stall rises only when the queue is full.
//   Result channel out_*: one word per input word, in order, held in an
//   output register until out_valid is high and out_stall low.
//   An integrate word steps the heading, rotates its displacement by twice
//   the heading and then forms the quaternion from the heading; a set word
//   only forms the quaternion. The shared iterative CORDIC, one step per
//   cycle, serves both rotations, so it runs twice per integrate word;
//   words are worked one at a time.
//   While out_stall is high and the output register is full, a finished
//   result waits in the engine; the queue keeps taking words until full.
//   Reset (rst_n low, synchronous) zeroes pose and latched velocities and
//   empties the queue; no result is pending afterwards.
`timescale 1ns / 1ps
module planar_odometry_integrator #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_yaw_rate,
  input  logic [19:0] in_time_step,
  input  logic [31:0] in_pose_x,
  input  logic [31:0] in_pose_y,
  input  logic [31:0] in_pose_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_heading,
  output logic [31:0] out_quat_w,
  output logic [31:0] out_quat_z,
  output logic [31:0] out_lin_vel_x,
  output logic [31:0] out_lin_vel_y,
  output logic [31:0] out_ang_vel,
  output logic        out_saturated
);

  poi_pkg::item_t in_item;
  poi_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  always_comb begin
    in_item.operation    = in_operation;
    in_item.vel_x        = in_vel_x;
    in_item.vel_y        = in_vel_y;
    in_item.yaw_rate     = in_yaw_rate;
    in_item.time_step    = in_time_step;
    in_item.pose_x       = in_pose_x;
    in_item.pose_y       = in_pose_y;
    in_item.pose_heading = in_pose_heading;
  end

  poi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  poi_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_heading   (out_heading),
    .out_quat_w    (out_quat_w),
    .out_quat_z    (out_quat_z),
    .out_lin_vel_x (out_lin_vel_x),
    .out_lin_vel_y (out_lin_vel_y),
    .out_ang_vel   (out_ang_vel),
    .out_saturated (out_saturated)
  );

endmodule

// ----- bench/odom_checker.sv -----
// Checker for the planar odometry integrator: predicts each pose word and compares it.
`timescale 1ns / 1ps
module odom_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_yaw_rate,
  input  logic [19:0] in_time_step,
  input  logic [31:0] in_pose_x,
  input  logic [31:0] in_pose_y,
  input  logic [31:0] in_pose_heading,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_pos_x,
  input  logic [31:0] out_pos_y,
  input  logic [31:0] out_heading,
  input  logic [31:0] out_quat_w,
  input  logic [31:0] out_quat_z,
  input  logic [31:0] out_lin_vel_x,
  input  logic [31:0] out_lin_vel_y,
  input  logic [31:0] out_ang_vel,
  input  logic        out_saturated,
  output int          fail_count,
  output int          pending_poses
);

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] quat_w;
    logic [31:0] quat_z;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] wz;
    logic        sat;
  } pose_t;

  localparam logic [31:0] ANGLE_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000};

  pose_t expected_poses[$];
  logic signed [63:0] pos_x_q, pos_y_q, vx_q, vy_q, wz_q;
  logic [31:0] head_q;

  function automatic logic signed [63:0] clip_q30(input logic signed [63:0] v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  task automatic sin_cos(input logic [31:0] angle, output logic signed [63:0] c,
                         output logic signed [63:0] s);
    logic flip;
    logic [31:0] a;
    logic signed [63:0] x, y, z, xs, ys;
    flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    a = flip ? angle + 32'h80000000 : angle;
    z = $signed(a);
    x = 64'sd652032875;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - $signed({32'd0, ANGLE_TAB[i]});
      end else begin
        x = x + ys; y = y - xs; z = z + $signed({32'd0, ANGLE_TAB[i]});
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip_q30(x);
    s = clip_q30(y);
  endtask

  function automatic logic signed [63:0] sat_pos(input logic signed [63:0] v, inout logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1; return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic advance_pose();
    logic hit;
    logic signed [63:0] dt, p, dxq, dyq, c, s, tx, ty, qc, qs;
    logic [63:0] mag, d;
    logic [31:0] step;
    pose_t e;
    hit = 1'b0;
    if (in_operation == poi_pkg::OP_SET) begin
      pos_x_q = $signed(in_pose_x);
      pos_y_q = $signed(in_pose_y);
      head_q = in_pose_heading;
    end else begin
      dt = {44'd0, in_time_step};
      vx_q = $signed(in_vel_x);
      vy_q = $signed(in_vel_y);
      wz_q = $signed(in_yaw_rate);
      p = wz_q * dt;
      mag = (p < 0) ? -p : p;
      d = (mag >> 32) * 64'd341782638 + (((mag & 64'hFFFFFFFF) * 64'd341782638) >> 32);
      step = d[31:0];
      if (p < 0) step = 32'd0 - step;
      head_q = head_q + step;
      sin_cos(head_q << 1, c, s);
      dxq = (vx_q * dt) >>> 18;
      dyq = (vy_q * dt) >>> 18;
      tx = ((dxq * c) >>> 28) - ((dyq * s) >>> 28);
      ty = ((dxq * s) >>> 28) + ((dyq * c) >>> 28);
      pos_x_q = sat_pos(pos_x_q + tx, hit);
      pos_y_q = sat_pos(pos_y_q + ty, hit);
    end
    sin_cos(head_q, qc, qs);
    e.pos_x = pos_x_q[31:0];
    e.pos_y = pos_y_q[31:0];
    e.heading = head_q;
    e.quat_w = qc[31:0];
    e.quat_z = qs[31:0];
    e.vx = vx_q[31:0];
    e.vy = vy_q[31:0];
    e.wz = wz_q[31:0];
    e.sat = hit;
    expected_poses.insert(expected_poses.size(), e);
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    if (fail_count < 10)
      $display("mismatch %s: expected %h, got %h at %0t", field, want, got, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      pos_x_q = 0; pos_y_q = 0; head_q = 0;
      vx_q = 0; vy_q = 0; wz_q = 0;
      expected_poses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word at %0t", $realtime);
          fail_count++;
        end else begin
          e = expected_poses.pop_front();
          if (out_pos_x !== e.pos_x) report("pos_x", e.pos_x, out_pos_x);
          if (out_pos_y !== e.pos_y) report("pos_y", e.pos_y, out_pos_y);
          if (out_heading !== e.heading) report("heading", e.heading, out_heading);
          if (out_quat_w !== e.quat_w) report("quat_w", e.quat_w, out_quat_w);
          if (out_quat_z !== e.quat_z) report("quat_z", e.quat_z, out_quat_z);
          if (out_lin_vel_x !== e.vx) report("lin_vel_x", e.vx, out_lin_vel_x);
          if (out_lin_vel_y !== e.vy) report("lin_vel_y", e.vy, out_lin_vel_y);
          if (out_ang_vel !== e.wz) report("ang_vel", e.wz, out_ang_vel);
          if (out_saturated !== e.sat) report("saturated", {31'd0, e.sat}, {31'd0, out_saturated});
        end
      end
      if (in_valid && !in_stall) advance_pose();
    end
    pending_poses = expected_poses.size();
  end

  initial begin
    fail_count = 0;
    pending_poses = 0;
  end
endmodule

// ----- bench/tb.sv -----
// Testbench top: stimulus and verdict for the planar odometry integrator.
`timescale 1ns / 1ps
module tb;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic [31:0] in_vel_x, in_vel_y, in_yaw_rate, in_pose_x, in_pose_y, in_pose_heading;
  logic [19:0] in_time_step;
  logic out_valid, out_stall, out_saturated;
  logic [31:0] out_pos_x, out_pos_y, out_heading, out_quat_w, out_quat_z;
  logic [31:0] out_lin_vel_x, out_lin_vel_y, out_ang_vel;
  int fail_count, pending_poses;
  int cycle_count;
  int stall_mode;

  planar_odometry_integrator u_dut (.*);

  odom_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous limit: ~1600 words plus stalls and gaps
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light and heavy stalling
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 255) - 128;
      3: return ($urandom_range(0, 65535) - 32768) * 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic op, input logic [31:0] vx, input logic [31:0] vy,
                      input logic [31:0] wz, input logic [19:0] dt, input logic [31:0] px,
                      input logic [31:0] py, input logic [31:0] ph);
    in_valid <= 1'b1;
    in_operation <= op;
    in_vel_x <= vx;
    in_vel_y <= vy;
    in_yaw_rate <= wz;
    in_time_step <= dt;
    in_pose_x <= px;
    in_pose_y <= py;
    in_pose_heading <= ph;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    logic [19:0] dt;
    case ($urandom_range(0, 3))
      0: dt = 20'($urandom);
      1: dt = 20'hFFFFF;
      default: dt = 20'($urandom_range(0, 4095));
    endcase
    if ($urandom_range(0, 9) == 0)
      send(poi_pkg::OP_SET, $urandom, $urandom, $urandom, 20'($urandom),
           rand_field(), rand_field(), $urandom);
    else
      send(poi_pkg::OP_INTEGRATE, rand_field(), rand_field(), rand_field(), dt,
           $urandom, $urandom, $urandom);
  endtask

  task automatic gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int burst;
    int sent;
    cycle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = poi_pkg::OP_INTEGRATE;
    in_vel_x = '0; in_vel_y = '0; in_yaw_rate = '0; in_time_step = '0;
    in_pose_x = '0; in_pose_y = '0; in_pose_heading = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, set, zero step, saturation, quadrant edges
    send(poi_pkg::OP_INTEGRATE, 32'h00010000, 32'h0, 32'h0, 20'h0, '0, '0, '0);
    send(poi_pkg::OP_INTEGRATE, 32'h00010000, 32'h00008000, 32'h00010000, 20'h10000,
         '0, '0, '0);
    send(poi_pkg::OP_INTEGRATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'hFFFFF,
         '0, '0, '0);
    send(poi_pkg::OP_INTEGRATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'hFFFFF,
         '0, '0, '0);
    send(poi_pkg::OP_INTEGRATE, 32'h80000000, 32'h80000000, 32'h80000000, 20'hFFFFF,
         '0, '0, '0);
    send(poi_pkg::OP_INTEGRATE, 32'h80000000, 32'h80000000, 32'h80000000, 20'hFFFFF,
         '0, '0, '0);
    send(poi_pkg::OP_SET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 32'h7FFFFFFF,
         32'h80000000, 32'h40000000);
    send(poi_pkg::OP_INTEGRATE, 32'h7FFFFFFF, 32'h0, 32'h0, 20'hFFFFF, '0, '0, '0);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, 32'h80000000, 32'h7FFFFFFF, 32'hC0000000);
    send(poi_pkg::OP_INTEGRATE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 20'hFFFFF, '0, '0, '0);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, '0, '0, 32'h80000000);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, '0, '0, 32'h20000000);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, '0, '0, 32'h60000000);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, '0, '0, 32'hA0000000);
    send(poi_pkg::OP_INTEGRATE, 32'hFFFF0000, 32'h00010000, 32'hFFFFFFFF, 20'h00001,
         '0, '0, '0);
    send(poi_pkg::OP_SET, '0, '0, '0, '0, '0, '0, '0);
    send(poi_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 20'h0, '0, '0, '0);

    // hold off until the queue and engine are empty
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_poses != 0) @(posedge clk);

    sent = 0;
    while (sent < 1500) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (burst) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 150));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_poses != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- planar_odometry_integrator.f -----
src/poi_pkg.sv
src/poi_front.sv
src/poi_cordic.sv
src/poi_back.sv
src/planar_odometry_integrator.sv
bench/odom_checker.sv
bench/tb.sv
